[rtl/c8_pkg.sv]
`timescale 1ns / 1ps
package c8_pkg;

  // memory and display geometry
  localparam int MEM_DEPTH   = 4096;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int COL_W       = $clog2(SCREEN_W);
  localparam int ROW_W       = $clog2(SCREEN_H);
  localparam int PIXELS      = SCREEN_W * SCREEN_H;
  localparam int STACK_DEPTH = 16;
  localparam int STK_W       = $clog2(STACK_DEPTH);
  localparam int SP_W        = STK_W + 1;

  localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
  localparam logic [ADDR_W-1:0] PC_START  = 12'h200;
  localparam int FONT_BYTES = 80;

  // item kinds
  localparam logic [1:0] FUNC_EXEC  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_PIXEL = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_STACK  = 2'd2;

  // major opcodes
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDX  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [11:0] NNN_CLS = 12'h0E0;
  localparam logic [11:0] NNN_RET = 12'h0EE;

  // alu sub-opcodes
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // misc sub-opcodes
  localparam logic [7:0] F_GDT  = 8'h07;
  localparam logic [7:0] F_KEY  = 8'h0A;
  localparam logic [7:0] F_SDT  = 8'h15;
  localparam logic [7:0] F_SST  = 8'h18;
  localparam logic [7:0] F_ADDI = 8'h1E;
  localparam logic [7:0] F_FONT = 8'h29;
  localparam logic [7:0] F_BCD  = 8'h33;
  localparam logic [7:0] F_STR  = 8'h55;
  localparam logic [7:0] F_LDR  = 8'h65;

  localparam logic [3:0] REG_F = 4'hF;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // main memory port request
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // display row port request
  typedef struct packed {
    logic                rd;
    logic                we;
    logic                clr;
    logic [ROW_W-1:0]    row;
    logic [SCREEN_W-1:0] wdata;
  } disp_req_t;

  // register file request
  typedef struct packed {
    logic       rd;
    logic [3:0] ra;
    logic [3:0] rb;
    logic       we;
    logic [3:0] wa;
    logic [7:0] wd;
  } vreg_req_t;

  // reset contents of one memory byte
  function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && off < ADDR_W'(FONT_BYTES)) return FONT[off[6:0]];
    return 8'h00;
  endfunction

  // decimal digits of a byte by reciprocal multiply: {hundreds, tens, ones}
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [13:0] ph;
    logic [15:0] pt;
    logic [1:0]  h;
    logic [4:0]  q;
    logic [3:0]  t;
    logic [3:0]  o;
    ph = 14'(v) * 14'd41;
    pt = 16'(v) * 16'd205;
    h  = ph[13:12];
    q  = pt[15:11];
    t  = 4'(q - 5'(h) * 5'd10);
    o  = 4'(v - 8'(q) * 8'd10);
    return {2'b00, h, t, o};
  endfunction

endpackage

[rtl/c8_main_mem.sv]
`timescale 1ns / 1ps
module c8_main_mem (
  input  logic              clk,
  input  logic              rst,
  input  c8_pkg::mem_req_t  req,
  output logic [7:0]        rdata,
  output logic              busy
);

  logic [7:0]                mem [c8_pkg::MEM_DEPTH];
  logic [c8_pkg::ADDR_W-1:0] clr_addr;

  // clearing pass after reset, one byte per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == c8_pkg::ADDR_W'(c8_pkg::MEM_DEPTH - 1)) busy <= 1'b0;
    end
  end

  // single port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= c8_pkg::init_byte(clr_addr);
    end else if (req.en) begin
      if (req.we) mem[req.addr] <= req.wdata;
      else rdata <= mem[req.addr];
    end
  end

endmodule

[rtl/c8_disp_mem.sv]
`timescale 1ns / 1ps
module c8_disp_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  c8_pkg::disp_req_t           req,
  output logic [c8_pkg::SCREEN_W-1:0] rdata
);

  logic [c8_pkg::SCREEN_W-1:0] rows [c8_pkg::SCREEN_H];
  logic [c8_pkg::SCREEN_H-1:0] row_ok;
  logic [c8_pkg::SCREEN_W-1:0] rraw;
  logic                        rvalid;

  // row storage, one row read or written per cycle
  always_ff @(posedge clk) begin
    if (req.we) rows[req.row] <= req.wdata;
    if (req.rd) rraw <= rows[req.row];
  end

  // row valid bits; a row never written since a clear reads as blank
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rvalid <= 1'b0;
    end else begin
      if (req.rd) rvalid <= row_ok[req.row];
      if (req.clr) row_ok <= '0;
      else if (req.we) row_ok[req.row] <= 1'b1;
    end
  end

  assign rdata = rvalid ? rraw : '0;

endmodule

[rtl/c8_vfile.sv]
`timescale 1ns / 1ps
module c8_vfile (
  input  logic              clk,
  input  logic              rst,
  input  c8_pkg::vreg_req_t req,
  output logic [7:0]        rdata_a,
  output logic [7:0]        rdata_b
);

  logic [7:0]  regs [16];
  logic [15:0] ok;
  logic [7:0]  raw_a;
  logic [7:0]  raw_b;
  logic        ok_a;
  logic        ok_b;

  // one write, two registered reads
  always_ff @(posedge clk) begin
    if (req.we) regs[req.wa] <= req.wd;
    if (req.rd) begin
      raw_a <= regs[req.ra];
      raw_b <= regs[req.rb];
    end
  end

  // valid bits stand for the zero reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      ok   <= '0;
      ok_a <= 1'b0;
      ok_b <= 1'b0;
    end else begin
      if (req.we) ok[req.wa] <= 1'b1;
      if (req.rd) begin
        ok_a <= ok[req.ra];
        ok_b <= ok[req.rb];
      end
    end
  end

  assign rdata_a = ok_a ? raw_a : 8'h00;
  assign rdata_b = ok_b ? raw_b : 8'h00;

endmodule

[rtl/chip8_cpu_step_unit.sv]
`timescale 1ns / 1ps
// throughput: one item at a time; the next item is taken once the result is in the
//   output register, which holds it while the consumer stalls
// reset: synchronous; a clearing pass loads memory with zeros and the font, ready low
module chip8_cpu_step_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  read_value,
  output logic        drew,
  output logic        beep,
  output logic [11:0] program_counter
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_F1   = 15'h0002,
    S_F2   = 15'h0004,
    S_EXE  = 15'h0008,
    S_WB   = 15'h0010,
    S_BCD  = 15'h0020,
    S_STR  = 15'h0040,
    S_STW  = 15'h0080,
    S_LDR  = 15'h0100,
    S_LDW  = 15'h0200,
    S_DR0  = 15'h0400,
    S_DR1  = 15'h0800,
    S_DR2  = 15'h1000,
    S_PX   = 15'h2000,
    S_DONE = 15'h4000
  } state_t;

  state_t                      st;
  logic [11:0]                 pc;
  logic [15:0]                 idx;
  logic [c8_pkg::SP_W-1:0]     sp;
  logic [7:0]                  delay_cnt;
  logic [7:0]                  sound_cnt;
  logic [11:0]                 stack [c8_pkg::STACK_DEPTH];
  logic [7:0]                  ir_hi;
  logic [7:0]                  ir_lo;
  logic [7:0]                  vx;
  logic [7:0]                  vy;
  logic [3:0]                  cnt;
  logic [7:0]                  spr;
  logic                        coll;
  logic [3:0]                  wq_idx [3];
  logic [7:0]                  wq_val [3];
  logic [1:0]                  wq_n;
  logic [3:0]                  bcd_d [3];
  logic [11:0]                 in_addr;
  logic [7:0]                  in_rnd;
  logic [1:0]                  res_status;
  logic                        res_readv;
  logic                        res_drew;
  logic                        res_beep;

  c8_pkg::mem_req_t            mreq;
  c8_pkg::disp_req_t           dreq;
  c8_pkg::vreg_req_t           vreq;
  logic [7:0]                  m_rdata;
  logic                        m_busy;
  logic [c8_pkg::SCREEN_W-1:0] d_rdata;
  logic [7:0]                  a;
  logic [7:0]                  b;

  c8_main_mem u_mem (.clk(clk), .rst(rst), .req(mreq), .rdata(m_rdata), .busy(m_busy));
  c8_disp_mem u_disp (.clk(clk), .rst(rst), .req(dreq), .rdata(d_rdata));
  c8_vfile u_vf (.clk(clk), .rst(rst), .req(vreq), .rdata_a(a), .rdata_b(b));

  // instruction fields
  logic [15:0] ir;
  logic [3:0]  op;
  logic [3:0]  x;
  logic [3:0]  y;
  logic [3:0]  n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [11:0] pc2;
  logic [11:0] pc4;
  logic [c8_pkg::STK_W-1:0] sp_top;

  assign ir     = {ir_hi, ir_lo};
  assign op     = ir[15:12];
  assign x      = ir[11:8];
  assign y      = ir[7:4];
  assign n      = ir[3:0];
  assign nn     = ir[7:0];
  assign nnn    = ir[11:0];
  assign pc2    = pc + 12'd2;
  assign pc4    = pc + 12'd4;
  assign sp_top = c8_pkg::STK_W'(sp - 1'b1);

  // alu result and carry/borrow flag
  logic [8:0] sum;
  logic [7:0] alu_res;
  logic [7:0] alu_flag;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    alu_res  = 8'h00;
    alu_flag = 8'h00;
    case (n)
      c8_pkg::ALU_MOV:  alu_res = b;
      c8_pkg::ALU_OR:   alu_res = a | b;
      c8_pkg::ALU_AND:  alu_res = a & b;
      c8_pkg::ALU_XOR:  alu_res = a ^ b;
      c8_pkg::ALU_ADD: begin
        alu_res  = sum[7:0];
        alu_flag = {7'd0, sum[8]};
      end
      c8_pkg::ALU_SUB: begin
        alu_res  = a - b;
        alu_flag = {7'd0, a >= b};
      end
      c8_pkg::ALU_SUBN: begin
        alu_res  = b - a;
        alu_flag = {7'd0, a <= b};
      end
      c8_pkg::ALU_SHR: begin
        // when VY is VF the freshly written flag is what gets shifted
        alu_res  = (y == c8_pkg::REG_F) ? 8'h00 : b >> 1;
        alu_flag = {7'd0, b[0]};
      end
      c8_pkg::ALU_SHL: begin
        alu_res  = (y == c8_pkg::REG_F) ? {6'd0, b[7], 1'b0} : b << 1;
        alu_flag = {7'd0, b[7]};
      end
      default: ;
    endcase
  end

  // sprite row geometry and xor mask
  logic [8:0]                  yy;
  logic                        row_in;
  logic [7:0]                  spr_rev;
  logic [c8_pkg::SCREEN_W-1:0] mask;
  logic                        hit;
  logic                        coll_n;

  assign yy      = {1'b0, vy} + 9'(cnt);
  assign row_in  = yy < 9'(c8_pkg::SCREEN_H);
  assign spr_rev = {spr[0], spr[1], spr[2], spr[3], spr[4], spr[5], spr[6], spr[7]};
  assign mask    = (vx < 8'(c8_pkg::SCREEN_W))
                   ? (c8_pkg::SCREEN_W'(spr_rev) << vx[c8_pkg::COL_W-1:0]) : '0;
  assign hit     = |(d_rdata & mask);
  assign coll_n  = coll | (row_in & hit);

  logic [11:0] idx_k;
  assign idx_k = idx[11:0] + 12'(cnt);

  assign in_ready = (st == S_IDLE) && !m_busy;

  // memory port requests per state
  always_comb begin
    mreq = '0;
    dreq = '0;
    vreq = '0;
    unique case (st)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (func == c8_pkg::FUNC_EXEC) begin
            mreq.en   = 1'b1;
            mreq.addr = pc;
          end else if (func == c8_pkg::FUNC_WRITE) begin
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = address;
            mreq.wdata = data;
          end else if (func == c8_pkg::FUNC_PIXEL && address < 12'(c8_pkg::PIXELS)) begin
            dreq.rd  = 1'b1;
            dreq.row = address[c8_pkg::COL_W +: c8_pkg::ROW_W];
          end
        end
      end
      S_F1: begin
        mreq.en   = 1'b1;
        mreq.addr = pc + 12'd1;
      end
      S_F2: begin
        vreq.rd = 1'b1;
        vreq.ra = (ir_hi[7:4] == c8_pkg::OP_JPV) ? 4'h0 : ir_hi[3:0];
        vreq.rb = m_rdata[7:4];
      end
      S_EXE: begin
        if (op == c8_pkg::OP_SYS && nnn == c8_pkg::NNN_CLS) dreq.clr = 1'b1;
      end
      S_WB: begin
        vreq.we = 1'b1;
        vreq.wa = wq_idx[0];
        vreq.wd = wq_val[0];
      end
      S_BCD: begin
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = idx_k;
        mreq.wdata = {4'h0, bcd_d[cnt[1:0]]};
      end
      S_STR: begin
        vreq.rd = 1'b1;
        vreq.ra = cnt;
      end
      S_STW: begin
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = idx_k;
        mreq.wdata = a;
      end
      S_LDR: begin
        mreq.en   = 1'b1;
        mreq.addr = idx_k;
      end
      S_LDW: begin
        vreq.we = 1'b1;
        vreq.wa = cnt;
        vreq.wd = m_rdata;
      end
      S_DR0: begin
        mreq.en   = 1'b1;
        mreq.addr = idx_k;
      end
      S_DR1: begin
        dreq.rd  = row_in;
        dreq.row = yy[c8_pkg::ROW_W-1:0];
      end
      S_DR2: begin
        dreq.we    = row_in;
        dreq.row   = yy[c8_pkg::ROW_W-1:0];
        dreq.wdata = d_rdata ^ mask;
      end
      S_PX: ;
      S_DONE: ;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      pc        <= c8_pkg::PC_START;
      idx       <= '0;
      sp        <= '0;
      delay_cnt <= '0;
      sound_cnt <= '0;
      wq_n      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && st != S_DONE) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            res_status <= c8_pkg::ST_OK;
            res_readv  <= 1'b0;
            res_drew   <= 1'b0;
            res_beep   <= 1'b0;
            in_addr    <= address;
            in_rnd     <= random_byte;
            unique case (func)
              c8_pkg::FUNC_EXEC: st <= S_F1;
              c8_pkg::FUNC_TICK: begin
                if (delay_cnt != 8'h00) delay_cnt <= delay_cnt - 1'b1;
                if (sound_cnt != 8'h00) sound_cnt <= sound_cnt - 1'b1;
                res_beep <= (sound_cnt == 8'h01);
                st       <= S_DONE;
              end
              c8_pkg::FUNC_WRITE: st <= S_DONE;
              c8_pkg::FUNC_PIXEL: st <= (address < 12'(c8_pkg::PIXELS)) ? S_PX : S_DONE;
              default: st <= S_DONE;
            endcase
          end
        end
        S_F1: begin
          ir_hi <= m_rdata;
          st    <= S_F2;
        end
        S_F2: begin
          ir_lo <= m_rdata;
          st    <= S_EXE;
        end
        S_EXE: begin
          st <= S_DONE;
          unique case (op)
            c8_pkg::OP_SYS: begin
              if (nnn == c8_pkg::NNN_CLS) begin
                res_drew <= 1'b1;
                pc       <= pc2;
              end else if (nnn == c8_pkg::NNN_RET) begin
                if (sp == '0) res_status <= c8_pkg::ST_STACK;
                else begin
                  sp <= sp - 1'b1;
                  pc <= stack[sp_top];
                end
              end else begin
                pc <= pc2;
              end
            end
            c8_pkg::OP_JP: pc <= nnn;
            c8_pkg::OP_CALL: begin
              if (sp >= c8_pkg::SP_W'(c8_pkg::STACK_DEPTH)) res_status <= c8_pkg::ST_STACK;
              else begin
                stack[sp[c8_pkg::STK_W-1:0]] <= pc2;
                sp <= sp + 1'b1;
                pc <= nnn;
              end
            end
            c8_pkg::OP_SEI:  pc <= (a == nn) ? pc4 : pc2;
            c8_pkg::OP_SNEI: pc <= (a != nn) ? pc4 : pc2;
            c8_pkg::OP_SER:  pc <= (a == b) ? pc4 : pc2;
            c8_pkg::OP_SNER: pc <= (a != b) ? pc4 : pc2;
            c8_pkg::OP_LDI: begin
              wq_idx[0] <= x;
              wq_val[0] <= nn;
              wq_n      <= 2'd1;
              st        <= S_WB;
              pc        <= pc2;
            end
            c8_pkg::OP_ADDI: begin
              wq_idx[0] <= x;
              wq_val[0] <= a + nn;
              wq_n      <= 2'd1;
              st        <= S_WB;
              pc        <= pc2;
            end
            c8_pkg::OP_ALU: begin
              unique case (n) inside
                c8_pkg::ALU_MOV, c8_pkg::ALU_OR, c8_pkg::ALU_AND, c8_pkg::ALU_XOR: begin
                  wq_idx[0] <= x;
                  wq_val[0] <= alu_res;
                  wq_n      <= 2'd1;
                  st        <= S_WB;
                  pc        <= pc2;
                end
                c8_pkg::ALU_ADD, c8_pkg::ALU_SUB, c8_pkg::ALU_SUBN: begin
                  // flag first, then the result, so the result wins for VF
                  wq_idx[0] <= c8_pkg::REG_F;
                  wq_val[0] <= alu_flag;
                  wq_idx[1] <= x;
                  wq_val[1] <= alu_res;
                  wq_n      <= 2'd2;
                  st        <= S_WB;
                  pc        <= pc2;
                end
                c8_pkg::ALU_SHR, c8_pkg::ALU_SHL: begin
                  // flag, shifted VY, then VX
                  wq_idx[0] <= c8_pkg::REG_F;
                  wq_val[0] <= alu_flag;
                  wq_idx[1] <= y;
                  wq_val[1] <= alu_res;
                  wq_idx[2] <= x;
                  wq_val[2] <= alu_res;
                  wq_n      <= 2'd3;
                  st        <= S_WB;
                  pc        <= pc2;
                end
                default: res_status <= c8_pkg::ST_BAD_OP;
              endcase
            end
            c8_pkg::OP_LDX: begin
              idx <= 16'(nnn);
              pc  <= pc2;
            end
            c8_pkg::OP_JPV: pc <= 12'(a) + nnn;
            c8_pkg::OP_RND: begin
              wq_idx[0] <= x;
              wq_val[0] <= in_rnd & nn;
              wq_n      <= 2'd1;
              st        <= S_WB;
              pc        <= pc2;
            end
            c8_pkg::OP_DRW: begin
              vx       <= a;
              vy       <= b;
              cnt      <= '0;
              coll     <= 1'b0;
              res_drew <= 1'b1;
              pc       <= pc2;
              if (n == 4'h0) begin
                wq_idx[0] <= c8_pkg::REG_F;
                wq_val[0] <= 8'h00;
                wq_n      <= 2'd1;
                st        <= S_WB;
              end else begin
                st <= S_DR0;
              end
            end
            c8_pkg::OP_KEY: ;
            c8_pkg::OP_MISC: begin
              unique case (nn)
                c8_pkg::F_GDT: begin
                  wq_idx[0] <= x;
                  wq_val[0] <= delay_cnt;
                  wq_n      <= 2'd1;
                  st        <= S_WB;
                  pc        <= pc2;
                end
                c8_pkg::F_SDT: begin
                  delay_cnt <= a;
                  pc        <= pc2;
                end
                c8_pkg::F_SST: begin
                  sound_cnt <= a;
                  pc        <= pc2;
                end
                c8_pkg::F_KEY: ;
                c8_pkg::F_ADDI: begin
                  idx <= idx + 16'(a);
                  pc  <= pc2;
                end
                c8_pkg::F_FONT: begin
                  idx <= 16'(c8_pkg::FONT_BASE) + 16'(a[3:0]) * 16'd5;
                  pc  <= pc2;
                end
                c8_pkg::F_BCD: begin
                  {bcd_d[0], bcd_d[1], bcd_d[2]} <= c8_pkg::bcd_digits(a);
                  cnt <= '0;
                  st  <= S_BCD;
                  pc  <= pc2;
                end
                c8_pkg::F_STR: begin
                  cnt <= '0;
                  st  <= S_STR;
                  pc  <= pc2;
                end
                c8_pkg::F_LDR: begin
                  cnt <= '0;
                  st  <= S_LDR;
                  pc  <= pc2;
                end
                default: res_status <= c8_pkg::ST_BAD_OP;
              endcase
            end
            default: ;
          endcase
        end
        S_WB: begin
          // drain the register write queue one entry per cycle
          wq_idx[0] <= wq_idx[1];
          wq_val[0] <= wq_val[1];
          wq_idx[1] <= wq_idx[2];
          wq_val[1] <= wq_val[2];
          wq_n      <= wq_n - 1'b1;
          if (wq_n == 2'd1) st <= S_DONE;
        end
        S_BCD: begin
          if (cnt == 4'd2) st <= S_DONE;
          else cnt <= cnt + 1'b1;
        end
        S_STR: st <= S_STW;
        S_STW: begin
          if (cnt == x) begin
            idx <= idx + 16'(x) + 16'd1;
            st  <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            st  <= S_STR;
          end
        end
        S_LDR: st <= S_LDW;
        S_LDW: begin
          if (cnt == x) begin
            idx <= idx + 16'(x) + 16'd1;
            st  <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            st  <= S_LDR;
          end
        end
        S_DR0: st <= S_DR1;
        S_DR1: begin
          spr <= m_rdata;
          st  <= S_DR2;
        end
        S_DR2: begin
          coll <= coll_n;
          if (cnt == n - 4'd1) begin
            wq_idx[0] <= c8_pkg::REG_F;
            wq_val[0] <= {7'd0, coll_n};
            wq_n      <= 2'd1;
            st        <= S_WB;
          end else begin
            cnt <= cnt + 1'b1;
            st  <= S_DR0;
          end
        end
        S_PX: begin
          res_readv <= d_rdata[in_addr[c8_pkg::COL_W-1:0]];
          st        <= S_DONE;
        end
        S_DONE: begin
          // load the output register once the previous result is taken
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            read_value      <= {7'd0, res_readv};
            drew            <= res_drew;
            beep            <= res_beep;
            program_counter <= pc;
            st              <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // write queue is drained before the next item
  a_wq_empty: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> (wq_n == 2'd0))
    else $error("register write queue not empty at idle");

  // stack pointer never passes the stack depth
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= c8_pkg::SP_W'(c8_pkg::STACK_DEPTH))
    else $error("stack pointer out of range");

  // a new result only comes from the finish step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == S_DONE))
    else $error("result shown without finishing an item");

endmodule
